>>> hw/rtl/hrc_pkg.sv
package hrc_pkg;

  localparam int unsigned LevelW = 16;
  localparam int unsigned ModeW  = 3;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDataW = 16;

  // register indexes on the config channel
  localparam logic [CfgIdxW-1:0] CFG_RAMP_RATE   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_LEVEL_BOUND = CfgIdxW'(1);

  // input op codes
  localparam logic OP_TICK     = 1'b0;
  localparam logic OP_SET_MODE = 1'b1;

  typedef enum logic [ModeW-1:0] {
    MODE_DOWN     = 3'd0,
    MODE_UP       = 3'd1,
    MODE_RAMPUP   = 3'd2,
    MODE_RAMPDOWN = 3'd3,
    MODE_TUNEUP   = 3'd4,
    MODE_TUNEDOWN = 3'd5
  } mode_e;

  // result of one update step
  typedef struct packed {
    logic [LevelW-1:0] level;
    mode_e             mode;
    logic              switch_off;
  } step_res_t;

endpackage

>>> hw/rtl/hrc_intf.sv
interface hrc_in_if import hrc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             op;
  logic [ModeW-1:0] new_mode;

  modport source (output valid, op, new_mode, input ready);
  modport sink   (input valid, op, new_mode, output ready);
endinterface

interface hrc_out_if import hrc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [LevelW-1:0] level;
  logic [ModeW-1:0]  mode;
  logic              switch_off;

  modport source (output valid, level, mode, switch_off, input ready);
  modport sink   (input valid, level, mode, switch_off, output ready);
endinterface

interface hrc_cfg_if import hrc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/hrc_step.sv
module hrc_step import hrc_pkg::*; (
  input  logic [LevelW-1:0] level_i,
  input  mode_e             mode_i,
  input  logic [LevelW-1:0] rate_i,
  input  logic [LevelW-1:0] bound_i,
  input  logic              op_i,
  input  logic [ModeW-1:0]  new_mode_i,
  output step_res_t         res_o
);

  logic [LevelW:0]   sum;
  logic [LevelW-1:0] diff;

  assign sum  = {1'b0, level_i} + {1'b0, rate_i};
  assign diff = level_i - rate_i;

  always_comb begin
    res_o.level      = level_i;
    res_o.mode       = mode_i;
    res_o.switch_off = 1'b0;
    if (op_i == OP_SET_MODE) begin
      // codes six and seven are ignored
      case (new_mode_i)
        MODE_DOWN, MODE_UP, MODE_RAMPUP, MODE_RAMPDOWN, MODE_TUNEUP,
        MODE_TUNEDOWN: res_o.mode = mode_e'(new_mode_i);
        default:       res_o.mode = mode_i;
      endcase
    end else begin
      case (mode_i)
        MODE_RAMPUP, MODE_TUNEUP: begin
          // 17-bit sum, clamp above the bound
          if (sum > {1'b0, bound_i}) begin
            res_o.level = bound_i;
            res_o.mode  = MODE_UP;
          end else begin
            res_o.level = sum[LevelW-1:0];
          end
        end
        MODE_RAMPDOWN, MODE_TUNEDOWN: begin
          if (level_i > rate_i) begin
            if (mode_i == MODE_TUNEDOWN && diff < bound_i) begin
              res_o.level = bound_i;
              res_o.mode  = MODE_UP;
            end else begin
              res_o.level = diff;
            end
          end else begin
            res_o.level = '0;
            if (mode_i == MODE_RAMPDOWN) begin
              res_o.mode       = MODE_DOWN;
              res_o.switch_off = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/hv_ramp_controller_core.sv
// High-voltage ramp sequencer core.
//
// Channels (valid/ready, a word moves when both are high):
//   in_i  : op (0 = one-second tick, 1 = set mode) and new_mode.
//   out_o : level, mode and switch_off after each input word; one result
//           word per input word, in order.
//   cfg_i : index/data writes; 0 = ramp rate, 1 = level bound. Other
//           indexes are dropped. Always ready; write only while idle.
// Path: an accepted word is held in the input register, then in the result
//   register, which drives out_o. Throughput is one word per cycle while
//   out_o.ready is high; the update logic is a single 17-bit add/compare plus
//   a subtract and clamp between the input register and the result register.
// Reset (rst_ni low, async): level 0, mode down, both config registers 0, no
//   words in flight.
// Stall: when out_o.ready is low the result register holds; the input
//   register still takes one more word, then in_i.ready drops until the
//   result word is taken.
module hv_ramp_controller_core import hrc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  hrc_in_if.sink     in_i,
  hrc_out_if.source  out_o,
  hrc_cfg_if.sink    cfg_i
);

  // configuration
  logic [LevelW-1:0] rate_q, bound_q;

  // controller state
  logic [LevelW-1:0] level_q;
  mode_e             mode_q;

  // input stage
  logic              s1_valid_q;
  logic              s1_op_q;
  logic [ModeW-1:0]  s1_mode_q;

  // result stage
  logic              s2_valid_q;
  step_res_t         s2_res_q;

  step_res_t         step_res;
  logic              s1_fire;
  logic              in_fire;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q  <= '0;
      bound_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_RAMP_RATE:   rate_q  <= cfg_i.data;
        CFG_LEVEL_BOUND: bound_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // stage 1 moves on when the result register is free or being drained
  assign s1_fire    = s1_valid_q && (!s2_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_fire;
  assign in_fire    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q   <= in_i.op;
      s1_mode_q <= in_i.new_mode;
    end
  end

  hrc_step u_step (
    .level_i    (level_q),
    .mode_i     (mode_q),
    .rate_i     (rate_q),
    .bound_i    (bound_q),
    .op_i       (s1_op_q),
    .new_mode_i (s1_mode_q),
    .res_o      (step_res)
  );

  // state commits when the word leaves stage 1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q    <= '0;
      mode_q     <= MODE_DOWN;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_fire) begin
        level_q <= step_res.level;
        mode_q  <= step_res.mode;
      end
      if (s1_fire) begin
        s2_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      s2_res_q <= step_res;
    end
  end

  assign out_o.valid      = s2_valid_q;
  assign out_o.level      = s2_res_q.level;
  assign out_o.mode       = s2_res_q.mode;
  assign out_o.switch_off = s2_res_q.switch_off;

  // switch-off only when ramp-down lands at zero
  a_off_means_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.switch_off |-> out_o.mode == MODE_DOWN && out_o.level == '0)
    else $error("switch_off without down/zero");

  // state only moves when a word passes stage 1
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_fire |=> $stable(level_q) && $stable(mode_q))
    else $error("state changed without a word");

  // a mode command never touches the level
  a_cmd_keeps_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_op_q == OP_SET_MODE |=> $stable(level_q))
    else $error("mode command changed level");

  // empty input stage must be ready
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_i.ready)
    else $error("input stalled while empty");

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

// Regression bench for the high-voltage ramp sequencer core.
module testbench;
  import hrc_pkg::*;

  // generous run limit, far above the slowest correct run
  localparam int unsigned LimitCycles = 400000;
  // long output hold-off used to fill the pipe and stall the input side
  localparam int unsigned HoldLen     = 300;
  // settle time after the last result
  localparam int unsigned SettleCycles = 4;

  logic clk_i;
  logic rst_ni;

  hrc_in_if  in_if ();
  hrc_out_if out_if ();
  hrc_cfg_if cfg_if ();

  hv_ramp_controller_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // 20 ns period
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------
  // Shadow copy of the sequencer: config, applied level and mode.
  // ---------------------------------------------------------------------
  logic [CfgDataW-1:0] sh_rate;
  logic [CfgDataW-1:0] sh_bound;
  logic [LevelW-1:0]   sh_level;
  logic [ModeW-1:0]    sh_mode;

  // predicted result words, oldest first
  step_res_t hv_step_q[$];

  int failures     = 0;
  int in_gap_pct   = 0;   // per-cycle chance the sender idles
  int out_stall_pct = 0;  // per-cycle chance the receiver stalls
  int hold_req     = 0;   // bumped by a test to start one long hold-off
  int hold_seen    = 0;
  int hold_left    = 0;

  // Apply one input word to the shadow state and return the result word.
  function automatic step_res_t next_hv_step(input logic op, input logic [ModeW-1:0] nm);
    step_res_t       res;
    logic [LevelW:0] sum;
    logic            off;
    off = 1'b0;
    if (op == OP_TICK) begin
      if (sh_mode == MODE_RAMPUP || sh_mode == MODE_TUNEUP) begin
        // 17-bit sum: never wraps, anything past the bound clamps
        sum = {1'b0, sh_level} + {1'b0, sh_rate};
        if (sum > {1'b0, sh_bound}) begin
          sum     = {1'b0, sh_bound};
          sh_mode = MODE_UP;
        end
        sh_level = sum[LevelW-1:0];
      end else if (sh_mode == MODE_RAMPDOWN || sh_mode == MODE_TUNEDOWN) begin
        if (sh_level > sh_rate) begin
          sh_level = sh_level - sh_rate;
          // tune-down stops at the bound and settles in up
          if (sh_mode == MODE_TUNEDOWN && sh_level < sh_bound) begin
            sh_level = sh_bound;
            sh_mode  = MODE_UP;
          end
        end else begin
          // floor at zero; only ramp-down switches the supply off
          sh_level = '0;
          if (sh_mode == MODE_RAMPDOWN) begin
            sh_mode = MODE_DOWN;
            off     = 1'b1;
          end
        end
      end
      // down and up: tick is a no-op
    end else if (nm <= MODE_TUNEDOWN) begin
      sh_mode = nm;
    end
    // codes six and seven fall through untouched
    res.level      = sh_level;
    res.mode       = mode_e'(sh_mode);
    res.switch_off = off;
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Result side: compare each accepted word, then drive ready.
  // Signals are read right after the edge, i.e. their pre-edge values.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    step_res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (hv_step_q.size() == 0) begin
        $error("unexpected result word: level %0d mode %0d switch_off %0d",
               out_if.level, out_if.mode, out_if.switch_off);
        failures++;
      end else begin
        want = hv_step_q.pop_front();
        if (out_if.level !== want.level) begin
          $error("level: expected %0d, actual %0d", want.level, out_if.level);
          failures++;
        end
        if (out_if.mode !== want.mode) begin
          $error("mode: expected %0d, actual %0d", want.mode, out_if.mode);
          failures++;
        end
        if (out_if.switch_off !== want.switch_off) begin
          $error("switch_off: expected %0d, actual %0d", want.switch_off, out_if.switch_off);
          failures++;
        end
      end
    end
    // one long hold-off per request, counted here
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HoldLen;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Offer one input word and wait for the handshake. valid stays high on
  // return so back-to-back words need only one assignment per edge.
  task automatic send_word(input logic op, input logic [ModeW-1:0] nm);
    if ($urandom_range(99) < in_gap_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < in_gap_pct);
    end
    in_if.valid    <= 1'b1;
    in_if.op       <= op;
    in_if.new_mode <= nm;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    hv_step_q.push_back(next_hv_step(op, nm));
  endtask

  // Drop valid and wait until every predicted word has come back.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (hv_step_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic cfg_accept();
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
  endtask

  // Program both registers while idle; optionally add a write to an
  // unused index, which must change nothing.
  task automatic program_regs(input logic [CfgDataW-1:0] rate,
                              input logic [CfgDataW-1:0] bound, input bit junk);
    wait_drained();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= CFG_RAMP_RATE;
    cfg_if.data  <= rate;
    cfg_accept();
    sh_rate = rate;
    cfg_if.index <= CFG_LEVEL_BOUND;
    cfg_if.data  <= bound;
    cfg_accept();
    sh_bound = bound;
    if (junk) begin
      cfg_if.index <= CfgIdxW'($urandom_range(2, (1 << CfgIdxW) - 1));
      cfg_if.data  <= CfgDataW'($urandom);
      cfg_accept();
    end
    cfg_if.valid <= 1'b0;
  endtask

  // Pick a register setting, biased to the extremes.
  task automatic random_regs();
    logic [CfgDataW-1:0] rate;
    logic [CfgDataW-1:0] bound;
    case ($urandom_range(0, 5))
      0:       rate = '0;
      1:       rate = 16'd1;
      2:       rate = '1;
      3, 4:    rate = CfgDataW'($urandom_range(1, 16'h0fff));
      default: rate = CfgDataW'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0:       bound = '0;
      1:       bound = '1;
      default: bound = CfgDataW'($urandom);
    endcase
    program_regs(rate, bound, $urandom_range(3) == 0);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Registers still at reset: ticks in down do nothing, codes 6/7 ignored.
  task automatic test_idle_after_reset();
    send_word(OP_TICK, ModeW'(0));
    send_word(OP_SET_MODE, ModeW'(6));
    send_word(OP_SET_MODE, ModeW'(7));
    send_word(OP_TICK, ModeW'(7));
  endtask

  // Ramp-up to a full-scale bound with saturation, tick in up, sum equal to
  // the bound (mode holds), and the 17-bit overflow of 0xffff + 1.
  task automatic test_rising();
    program_regs(16'h7000, 16'hffff, 1'b1);
    send_word(OP_SET_MODE, MODE_RAMPUP);
    repeat (3) send_word(OP_TICK, ModeW'(0));
    send_word(OP_TICK, ModeW'(0));
    program_regs(16'h0000, 16'hffff, 1'b0);
    send_word(OP_SET_MODE, MODE_TUNEUP);
    send_word(OP_TICK, ModeW'(0));
    program_regs(16'h0001, 16'hffff, 1'b0);
    send_word(OP_TICK, ModeW'(0));
  endtask

  // Tune-down: plain step, floor at zero (mode holds), and the lower clamp
  // at the bound that moves to up.
  task automatic test_falling();
    program_regs(16'h8000, 16'h7800, 1'b0);
    send_word(OP_SET_MODE, MODE_TUNEDOWN);
    send_word(OP_TICK, ModeW'(0));
    send_word(OP_TICK, ModeW'(0));
    send_word(OP_SET_MODE, MODE_TUNEUP);
    send_word(OP_TICK, ModeW'(0));
    program_regs(16'h0100, 16'h7800, 1'b0);
    send_word(OP_SET_MODE, MODE_TUNEDOWN);
    send_word(OP_TICK, ModeW'(0));
  endtask

  // Ramp-down to zero raises switch_off and lands in down.
  task automatic test_ramp_down_off();
    program_regs(16'h4000, 16'h7800, 1'b0);
    send_word(OP_SET_MODE, MODE_RAMPDOWN);
    send_word(OP_TICK, ModeW'(0));
    send_word(OP_TICK, ModeW'(0));
    send_word(OP_TICK, ModeW'(0));
    send_word(OP_SET_MODE, MODE_UP);
    send_word(OP_TICK, ModeW'(0));
    send_word(OP_SET_MODE, MODE_DOWN);
  endtask

  // Output held off for a long stretch while words keep coming: the core
  // fills its two registers and must hold in_i.ready low without loss.
  task automatic test_backpressure();
    in_gap_pct    = 0;
    out_stall_pct = 0;
    program_regs(16'h0100, 16'hf000, 1'b1);
    hold_req <= hold_req + 1;
    send_word(OP_SET_MODE, MODE_RAMPUP);
    repeat (40) send_word(OP_TICK, ModeW'($urandom));
    send_word(OP_SET_MODE, MODE_RAMPDOWN);
    repeat (20) send_word(OP_TICK, ModeW'($urandom));
    wait_drained();
  endtask

  // Mostly a valid mode command followed by a run of ticks; the rest is
  // single random words, codes 6/7 included. Registers change every so often.
  task automatic run_phase(input int n, input int in_pct, input int out_pct);
    int sent;
    int next_cfg;
    in_gap_pct    = in_pct;
    out_stall_pct = out_pct;
    sent          = 0;
    next_cfg      = 0;
    while (sent < n) begin
      if (sent >= next_cfg) begin
        random_regs();
        next_cfg = sent + $urandom_range(40, 90);
      end
      if ($urandom_range(99) < 80) begin
        send_word(OP_SET_MODE, ModeW'($urandom_range(0, 5)));
        sent++;
        repeat ($urandom_range(1, 12)) begin
          send_word(OP_TICK, ModeW'($urandom));
          sent++;
        end
      end else begin
        send_word(1'($urandom), ModeW'($urandom));
        sent++;
      end
    end
  endtask

  task automatic test_random_traffic();
    run_phase(650, 9, 80);
    run_phase(650, 80, 9);
    run_phase(650, 0, 0);
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.op        = OP_TICK;
    in_if.new_mode  = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = CFG_RAMP_RATE;
    cfg_if.data     = '0;
    out_if.ready    = 1'b0;
    sh_rate         = '0;
    sh_bound        = '0;
    sh_level        = '0;
    sh_mode         = MODE_DOWN;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_after_reset();
    test_rising();
    test_falling();
    test_ramp_down_off();
    test_backpressure();
    test_random_traffic();

    wait_drained();
    if (failures == 0) begin
      $display("hv_ramp_controller_core regression: pass");
    end else begin
      $display("hv_ramp_controller_core regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    repeat (LimitCycles) @(posedge clk_i);
    $display("hv_ramp_controller_core regression: fail");
    $finish;
  end

endmodule
